### src/cau_pkg.sv
// Package for the complex arithmetic unit: opcodes, status codes, word width
// and the packed item types of the input and result channels. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int WORD_BITS = 16;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic [1:0]                  status;
  } cau_out_t;

endpackage

`default_nettype wire

### src/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: pipelined add, subtract, multiply,
// divide and modulus on signed fixed point operands. Depends on cau_pkg.
//
// Usage: an item (opcode and two complex operands) is taken on the input
// channel at a clock edge with in_valid high and in_stall low. Each item
// gives exactly one result item on the output channel, in order.
// Throughput: one item per cycle, every opcode, unless the receiver stalls.
// The pipeline has WORD_BITS + 6 register stages (22 at 16 bits): three for
// products, sums and magnitudes, one for the divide overflow check,
// WORD_BITS + 1 stages of a restoring divider (one quotient bit each;
// the square root takes one root bit in each of the first WORD_BITS
// of them), and the output register.
// Reset (synchronous, active low) empties the pipeline; no results are
// pending afterwards. While the receiver stalls a valid result the whole
// pipeline holds and in_stall is raised; nothing is lost or repeated.
// Divide by zero returns zeros with the divide-by-zero status; clamped
// components set the saturation status.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cau_pkg::cau_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cau_pkg::cau_out_t     out_data
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int RW = 2 * W + 1;
  localparam int NI = W + 1;
  localparam int NW = PW + F;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] val;
    logic         sat;
  } cres_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [W:0]    add_re;
    logic signed [W:0]    add_im;
    logic signed [W:0]    sub_re;
    logic signed [W:0]    sub_im;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] p_br2;
    logic signed [PW-1:0] p_bi2;
    logic signed [PW-1:0] p_ar2;
    logic signed [PW-1:0] p_ai2;
  } s1_t;

  typedef struct packed {
    logic [2:0]           op;
    cres_t                sres_re;
    cres_t                sres_im;
    logic signed [SW-1:0] mul_re;
    logic signed [SW-1:0] mul_im;
    logic signed [SW-1:0] num_re;
    logic signed [SW-1:0] num_im;
    logic [PW-1:0]        den;
    logic [PW-1:0]        sq;
  } s2_t;

  typedef struct packed {
    logic [2:0]    op;
    cres_t         sres_re;
    cres_t         sres_im;
    logic          neg_re;
    logic          neg_im;
    logic [PW-1:0] mag_re;
    logic [PW-1:0] mag_im;
    logic [PW-1:0] den;
    logic [PW-1:0] sq;
  } s3_t;

  typedef struct packed {
    logic [2:0]    op;
    cres_t         sres_re;
    cres_t         sres_im;
    logic [PW-1:0] den;
    logic          den_zero;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [PW-1:0] mag_re;
    logic [PW-1:0] mag_im;
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [W:0]    q_re;
    logic [W:0]    q_im;
    logic [PW-1:0] sq;
    logic [W+1:0]  srem;
    logic [W-1:0]  root;
  } it_t;

  // clamp a W+1 bit sum to the word
  function automatic cres_t sat_short(logic signed [W:0] x);
    cres_t r;
    if (x[W] != x[W-1]) begin
      r.sat = 1'b1;
      r.val = x[W] ? MINV : MAXV;
    end else begin
      r.sat = 1'b0;
      r.val = x[W-1:0];
    end
    return r;
  endfunction

  // clamp a wide signed value to the word
  function automatic cres_t sat_wide(logic signed [SW-1:0] x);
    cres_t r;
    if (x[SW-1:W-1] != {(SW-W+1){x[SW-1]}}) begin
      r.sat = 1'b1;
      r.val = x[SW-1] ? MINV : MAXV;
    end else begin
      r.sat = 1'b0;
      r.val = x[W-1:0];
    end
    return r;
  endfunction

  // one restoring divide step: {quotient bit, new remainder}
  function automatic logic [RW:0] div_bit(logic [RW-1:0] rem, logic nb,
                                          logic [PW-1:0] den);
    logic [RW-1:0] sh;
    logic [RW-1:0] diff;
    sh   = {rem[RW-2:0], nb};
    diff = sh - RW'(den);
    if (sh >= RW'(den)) begin
      return {1'b1, diff};
    end
    return {1'b0, sh};
  endfunction

  // one square root digit step: {new root, new remainder}
  function automatic logic [2*W+1:0] sqrt_bit(logic [W+1:0] srem,
                                               logic [W-1:0] root,
                                               logic [1:0] pair);
    logic [W+1:0] sh;
    logic [W+1:0] trial;
    sh    = {srem[W-1:0], pair};
    trial = {root, 2'b01};
    if (sh >= trial) begin
      return {root[W-2:0], 1'b1, sh - trial};
    end
    return {root[W-2:0], 1'b0, sh};
  endfunction

  function automatic cres_t div_out(logic neg, logic ovf, logic [W:0] q);
    cres_t      r;
    logic [W:0] nq;
    nq    = -q;
    r.sat = 1'b0;
    r.val = neg ? nq[W-1:0] : q[W-1:0];
    if (ovf || (!neg && q > (W+1)'(MAXV)) || (neg && q > {1'b0, MINV})) begin
      r.sat = 1'b1;
      r.val = neg ? MINV : MAXV;
    end
    return r;
  endfunction

  logic          en;
  logic          v1_r, v2_r, v3_r;
  logic [NI:0]   itv_r;
  s1_t           s1_r, s1_nxt;
  s2_t           s2_r, s2_nxt;
  s3_t           s3_r, s3_nxt;
  it_t           it_r [0:NI];
  it_t           it0_nxt;
  cau_pkg::cau_out_t out_r, out_nxt;
  logic          out_valid_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1: sums and all products
  always_comb begin
    s1_nxt.op     = in_data.op;
    s1_nxt.add_re = (W+1)'(in_data.a_re) + (W+1)'(in_data.b_re);
    s1_nxt.add_im = (W+1)'(in_data.a_im) + (W+1)'(in_data.b_im);
    s1_nxt.sub_re = (W+1)'(in_data.a_re) - (W+1)'(in_data.b_re);
    s1_nxt.sub_im = (W+1)'(in_data.a_im) - (W+1)'(in_data.b_im);
    s1_nxt.p_rr   = PW'(in_data.a_re) * PW'(in_data.b_re);
    s1_nxt.p_ii   = PW'(in_data.a_im) * PW'(in_data.b_im);
    s1_nxt.p_ri   = PW'(in_data.a_re) * PW'(in_data.b_im);
    s1_nxt.p_ir   = PW'(in_data.a_im) * PW'(in_data.b_re);
    s1_nxt.p_br2  = PW'(in_data.b_re) * PW'(in_data.b_re);
    s1_nxt.p_bi2  = PW'(in_data.b_im) * PW'(in_data.b_im);
    s1_nxt.p_ar2  = PW'(in_data.a_re) * PW'(in_data.a_re);
    s1_nxt.p_ai2  = PW'(in_data.a_im) * PW'(in_data.a_im);
  end

  // stage 2: product sums, add/sub clamp
  always_comb begin
    s2_nxt.op     = s1_r.op;
    s2_nxt.mul_re = SW'(s1_r.p_rr) - SW'(s1_r.p_ii);
    s2_nxt.mul_im = SW'(s1_r.p_ri) + SW'(s1_r.p_ir);
    s2_nxt.num_re = SW'(s1_r.p_rr) + SW'(s1_r.p_ii);
    s2_nxt.num_im = SW'(s1_r.p_ir) - SW'(s1_r.p_ri);
    s2_nxt.den    = $unsigned(s1_r.p_br2) + $unsigned(s1_r.p_bi2);
    s2_nxt.sq     = $unsigned(s1_r.p_ar2) + $unsigned(s1_r.p_ai2);
    if (s1_r.op == cau_pkg::OP_SUB) begin
      s2_nxt.sres_re = sat_short(s1_r.sub_re);
      s2_nxt.sres_im = sat_short(s1_r.sub_im);
    end else begin
      s2_nxt.sres_re = sat_short(s1_r.add_re);
      s2_nxt.sres_im = sat_short(s1_r.add_im);
    end
  end

  // stage 3: floored product, divide numerator magnitudes
  always_comb begin
    logic signed [SW-1:0] abs_re;
    logic signed [SW-1:0] abs_im;
    abs_re        = s2_r.num_re[SW-1] ? -s2_r.num_re : s2_r.num_re;
    abs_im        = s2_r.num_im[SW-1] ? -s2_r.num_im : s2_r.num_im;
    s3_nxt.op     = s2_r.op;
    s3_nxt.neg_re = s2_r.num_re[SW-1];
    s3_nxt.neg_im = s2_r.num_im[SW-1];
    s3_nxt.mag_re = abs_re[PW-1:0];
    s3_nxt.mag_im = abs_im[PW-1:0];
    s3_nxt.den    = s2_r.den;
    s3_nxt.sq     = s2_r.sq;
    if (s2_r.op == cau_pkg::OP_MUL) begin
      s3_nxt.sres_re = sat_wide(s2_r.mul_re >>> F);
      s3_nxt.sres_im = sat_wide(s2_r.mul_im >>> F);
    end else begin
      s3_nxt.sres_re = s2_r.sres_re;
      s3_nxt.sres_im = s2_r.sres_im;
    end
  end

  // stage 4: quotient overflow check and divider start
  always_comb begin
    logic [NW-1:0] nsh_re;
    logic [NW-1:0] nsh_im;
    nsh_re           = (NW'(s3_r.mag_re) << F) >> NI;
    nsh_im           = (NW'(s3_r.mag_im) << F) >> NI;
    it0_nxt.op       = s3_r.op;
    it0_nxt.sres_re  = s3_r.sres_re;
    it0_nxt.sres_im  = s3_r.sres_im;
    it0_nxt.den      = s3_r.den;
    it0_nxt.den_zero = (s3_r.den == '0);
    it0_nxt.neg_re   = s3_r.neg_re;
    it0_nxt.neg_im   = s3_r.neg_im;
    it0_nxt.ovf_re   = (nsh_re >= NW'(s3_r.den));
    it0_nxt.ovf_im   = (nsh_im >= NW'(s3_r.den));
    it0_nxt.mag_re   = s3_r.mag_re;
    it0_nxt.mag_im   = s3_r.mag_im;
    it0_nxt.rem_re   = RW'(nsh_re);
    it0_nxt.rem_im   = RW'(nsh_im);
    it0_nxt.q_re     = '0;
    it0_nxt.q_im     = '0;
    it0_nxt.sq       = s3_r.sq;
    it0_nxt.srem     = '0;
    it0_nxt.root     = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      s3_r     <= s3_nxt;
      it_r[0]  <= it0_nxt;
      out_r    <= out_nxt;
    end
  end

  // divider and square root stages, one quotient bit each and one root bit in all but the last
  for (genvar k = 1; k <= NI; k++) begin : g_iter
    localparam int IB = NI - k;
    logic nb_re;
    logic nb_im;
    it_t  nxt;

    if (IB >= F) begin : g_nbit
      assign nb_re = it_r[k-1].mag_re[IB-F];
      assign nb_im = it_r[k-1].mag_im[IB-F];
    end else begin : g_nzero
      assign nb_re = 1'b0;
      assign nb_im = 1'b0;
    end

    always_comb begin
      logic [RW:0]    dr;
      logic [RW:0]    di;
      logic [2*W+1:0] sr;
      nxt  = it_r[k-1];
      dr   = div_bit(it_r[k-1].rem_re, nb_re, it_r[k-1].den);
      di   = div_bit(it_r[k-1].rem_im, nb_im, it_r[k-1].den);
      sr   = '0;
      nxt.rem_re = dr[RW-1:0];
      nxt.rem_im = di[RW-1:0];
      nxt.q_re   = {it_r[k-1].q_re[W-1:0], dr[RW]};
      nxt.q_im   = {it_r[k-1].q_im[W-1:0], di[RW]};
      if (k <= W) begin
        sr = sqrt_bit(it_r[k-1].srem, it_r[k-1].root,
                      it_r[k-1].sq[PW-1-2*(k-1) -: 2]);
        nxt.root = sr[2*W+1:W+2];
        nxt.srem = sr[W+1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k] <= nxt;
      end
    end
  end

  // result select
  always_comb begin
    cres_t dre;
    cres_t dim;
    dre = div_out(it_r[NI].neg_re, it_r[NI].ovf_re, it_r[NI].q_re);
    dim = div_out(it_r[NI].neg_im, it_r[NI].ovf_im, it_r[NI].q_im);
    out_nxt.res_re = '0;
    out_nxt.res_im = '0;
    out_nxt.status = cau_pkg::ST_OK;
    unique case (it_r[NI].op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        out_nxt.res_re = it_r[NI].sres_re.val;
        out_nxt.res_im = it_r[NI].sres_im.val;
        if (it_r[NI].sres_re.sat || it_r[NI].sres_im.sat) begin
          out_nxt.status = cau_pkg::ST_SAT;
        end
      end
      cau_pkg::OP_DIV: begin
        if (it_r[NI].den_zero) begin
          out_nxt.status = cau_pkg::ST_DIV0;
        end else begin
          out_nxt.res_re = dre.val;
          out_nxt.res_im = dim.val;
          if (dre.sat || dim.sat) begin
            out_nxt.status = cau_pkg::ST_SAT;
          end
        end
      end
      cau_pkg::OP_MOD: begin
        if (it_r[NI].root[W-1]) begin
          out_nxt.res_re = MAXV;
          out_nxt.status = cau_pkg::ST_SAT;
        end else begin
          out_nxt.res_re = it_r[NI].root;
        end
      end
      default: begin
        out_nxt.status = cau_pkg::ST_OK;
      end
    endcase
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      itv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      itv_r       <= {itv_r[NI-1:0], v3_r};
      out_valid_r <= itv_r[NI];
    end
  end

endmodule

`default_nettype wire

### src/cau_checker.sv
// Port-level assertions for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
`timescale 1ns / 1ps
`default_nettype none

module cau_assertions (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire cau_pkg::cau_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result item changed");

  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output free");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == cau_pkg::ST_DIV0
      |-> out_data.res_re == '0 && out_data.res_im == '0)
    else $error("divide by zero with nonzero result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item after reset");

endmodule

bind complex_arithmetic_unit cau_assertions u_cau_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### bench/cau_checker.sv
// Checker for the complex arithmetic unit: watches both channels, predicts each
// result from the accepted item and compares field by field. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  cau_pkg::cau_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  cau_pkg::cau_out_t out_data,
  output int                fail_count,
  output int                pending
);

  localparam int FRAC = 8;
  localparam longint WMAX = 32767;
  localparam longint WMIN = -32768;

  cau_pkg::cau_out_t result_fifo[$];
  int                result_count;

  function automatic longint clamp_word(input longint v, inout bit sat);
    if (v > WMAX) begin
      sat = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat = 1;
      return WMIN;
    end
    return v;
  endfunction

  // n * 2^FRAC / d truncated toward zero, d positive; magnitude 32769 if |n| / d exceeds 32768
  function automatic longint fixed_quotient(input longint n, input longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = mag / d;
    if (q > 32768) q = 32769;
    else q = (mag << FRAC) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
        r = r + (longint'(1) << b);
    return r;
  endfunction

  function automatic cau_pkg::cau_out_t compute_result(input cau_pkg::cau_in_t x);
    cau_pkg::cau_out_t r;
    longint ar, ai, br, bi, vr, vi, den;
    bit sat;
    ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im;
    sat = 0;
    vr = 0;
    vi = 0;
    r.status = cau_pkg::ST_OK;
    case (x.op)
      cau_pkg::OP_ADD: begin vr = ar + br; vi = ai + bi; end
      cau_pkg::OP_SUB: begin vr = ar - br; vi = ai - bi; end
      cau_pkg::OP_MUL: begin
        vr = (ar * br - ai * bi) >>> FRAC;
        vi = (ar * bi + ai * br) >>> FRAC;
      end
      cau_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.status = cau_pkg::ST_DIV0;
        else begin
          vr = fixed_quotient(ar * br + ai * bi, den);
          vi = fixed_quotient(ai * br - ar * bi, den);
        end
      end
      cau_pkg::OP_MOD: vr = int_sqrt(ar * ar + ai * ai);
      default: ;
    endcase
    r.res_re = 16'(clamp_word(vr, sat));
    r.res_im = 16'(clamp_word(vi, sat));
    if (sat && r.status == cau_pkg::ST_OK) r.status = cau_pkg::ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what, got,
             want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cau_pkg::cau_out_t want;
    if (!rst_n) begin
      result_fifo.delete();
      result_count = 0;
    end else begin
      if (in_valid && !in_stall) result_fifo.push_back(compute_result(in_data));
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) report_mismatch("unexpected item", 1, 0);
        else begin
          want = result_fifo.pop_front();
          if (out_data.res_re !== want.res_re)
            report_mismatch("res_re", out_data.res_re, want.res_re);
          if (out_data.res_im !== want.res_im)
            report_mismatch("res_im", out_data.res_im, want.res_im);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
        result_count++;
      end
    end
    pending = result_fifo.size();
  end
endmodule

### bench/tb_top.sv
// Top of the complex arithmetic unit bench: clock, reset, stimulus and verdict.
// Depends on cau_pkg, complex_arithmetic_unit and cau_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = cau_pkg::WORD_BITS + 5;
  localparam longint CYCLE_LIMIT = 200000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_stall;
  cau_pkg::cau_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 0;
  cau_pkg::cau_out_t out_data;
  int                fail_count;
  int                pending;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                items_sent = 0;
  longint            cycle_count = 0;

  always #5 clk = ~clk;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  cau_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(512)) - 256);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // hold the item until accepted, with random gaps before it
  task automatic send_item(input cau_pkg::cau_in_t x);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ops(input logic [2:0] op, input logic [15:0] ar,
                          input logic [15:0] ai, input logic [15:0] br,
                          input logic [15:0] bi);
    cau_pkg::cau_in_t x;
    x.op = op; x.a_re = ar; x.a_im = ai; x.b_re = br; x.b_im = bi;
    send_item(x);
  endtask

  task automatic send_random(input int n);
    cau_pkg::cau_in_t x;
    repeat (n) begin
      x.op = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      x.a_re = pick_word(); x.a_im = pick_word();
      x.b_re = pick_word(); x.b_im = pick_word();
      if (x.op == cau_pkg::OP_DIV && $urandom_range(19) == 0) begin
        x.b_re = 0;
        x.b_im = 0;
      end
      send_item(x);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, every opcode, saturation, zero divisor, unused codes
    send_ops(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_ops(cau_pkg::OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
    send_ops(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_ops(cau_pkg::OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0001);
    send_ops(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_ops(cau_pkg::OP_MUL, 16'h0180, 16'hff80, 16'h0200, 16'h0100);
    send_ops(cau_pkg::OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_ops(cau_pkg::OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_ops(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_ops(cau_pkg::OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
    send_ops(cau_pkg::OP_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h8000);
    send_ops(cau_pkg::OP_MOD, 16'h8000, 16'h8000, 16'h1234, 16'h5678);
    send_ops(cau_pkg::OP_MOD, 16'h0300, 16'h0400, 16'h0000, 16'h0000);
    send_ops(cau_pkg::OP_MOD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_ops(3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_ops(3'd6, 16'h8000, 16'h1111, 16'h0000, 16'h0000);
    send_ops(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_random(200);
    idle_pct = 61;
    send_random(300);
    // hold off until the pipeline has drained
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    idle_pct = 0;
    stall_pct = 61;
    send_random(300);
    idle_pct = 21;
    stall_pct = 21;
    send_random(330);
    in_valid <= 0;
    idle_pct = 0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("%0d items sent over all opcodes, extremes and idle or stall mixes",
             items_sent);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

### files.f
src/cau_pkg.sv
src/complex_arithmetic_unit.sv
src/cau_checker.sv
bench/cau_checker.sv
bench/tb_top.sv
